### rtl/core/packbits_plane_decoder_macros.svh
// assertion macros for the packbits plane decoder
`ifndef PACKBITS_PLANE_DECODER_MACROS_SVH
`define PACKBITS_PLANE_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/pbd_pkg.sv
// shared types and constants of the packbits plane decoder
`default_nettype none

package pbd_pkg;

	// plane limits
	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 1024;
	localparam int ROW_W    = $clog2(MAX_ROWS);

	// field widths
	localparam int BYTE_W     = 8;
	localparam int DIM_W      = 11;
	localparam int LANE_W     = 2;
	localparam int ADDR_W     = 22;
	localparam int BASE_W     = 20;
	localparam int LEN_W      = 8;
	localparam int STAT_W     = 2;
	localparam int CNT_W      = 16;
	localparam int PH_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// item queue between front and back, depth a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	// decode phases
	localparam logic [PH_W-1:0] PH_HDR_HI = 3'd0;
	localparam logic [PH_W-1:0] PH_HDR_LO = 3'd1;
	localparam logic [PH_W-1:0] PH_CNT_HI = 3'd2;
	localparam logic [PH_W-1:0] PH_CNT_LO = 3'd3;
	localparam logic [PH_W-1:0] PH_DATA   = 3'd4;
	localparam logic [PH_W-1:0] PH_SINK   = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_COMP = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_SHORT    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LANE   = 2'd2;

	// packbits header values
	localparam logic [BYTE_W-1:0]  PB_NOOP     = 8'h80;
	localparam logic [BYTE_W:0]    PB_REP_BASE = 9'd257;
	localparam logic [LEN_W-1:0]   RUN_MAX     = 8'd128;

	typedef struct packed {
		logic [DIM_W-1:0]  plane_width;
		logic [DIM_W-1:0]  plane_height;
		logic [LANE_W-1:0] channel_select;
	} cfg_t;

	// classified input item
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
		logic              is_lit;
		logic              is_noop;
		logic [LEN_W-1:0]  lit_len;
		logic [LEN_W-1:0]  rep_len;
	} item_t;

	typedef struct packed {
		logic              run;
		logic              done;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] val;
		logic [LEN_W-1:0]  len;
		logic [STAT_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic pop;
		logic walking;
	} bk_stat_t;

endpackage

`default_nettype wire

### rtl/core/pbd_stream_if.sv
// byte and run channel interfaces of the packbits plane decoder
`default_nettype none

interface pbd_in_if import pbd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface pbd_out_if import pbd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] dest_address;
	logic [BYTE_W-1:0] pixel_value;
	logic [LEN_W-1:0]  run_length;
	logic [STAT_W-1:0] status;
	logic              plane_done;

	modport source(output valid, output dest_address, output pixel_value,
		output run_length, output status, output plane_done, input ready);
	modport sink(input valid, input dest_address, input pixel_value,
		input run_length, input status, input plane_done, output ready);
endinterface

`default_nettype wire

### rtl/core/packbits_plane_decoder.sv
// Packbits plane decoder: plane bytes in, channel runs out.
// byte_ch carries one plane byte per item with last_byte on the final byte of
// the buffer. Two header bytes select raw or packbits; in packbits mode the
// per-row byte counts follow and are kept in a 1024 x 16 table.
// run_ch carries one run per item: interleaved byte address of its first
// pixel, value, length, status and plane_done. Status-only items have a zero
// length.
// Throughput: one byte per cycle while run_ch accepts results. In packbits mode
// the last count byte and the byte that ends a row are followed by a count table
// read of the next row, and every following row with a zero count by another
// read; the single port of the count table sets this.
// A result passes the item queue and the output register after its byte is
// accepted, later by the count reads above. The back end stalls while run_ch
// holds an unaccepted item and during count reads; a 4-item queue keeps byte_ch
// ready until it fills. Configuration is written by the user through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
// Reset clears the decoder to expect a header and sets width and height to 1,
// lane to 0. The count table has no reset and no clearing pass.
`default_nettype none
`include "packbits_plane_decoder_macros.svh"

module packbits_plane_decoder import pbd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pbd_in_if.sink                byte_ch,
	pbd_out_if.source             run_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	logic              push;
	item_t             push_item;
	logic              q_valid;
	item_t             q_item;
	logic              q_full;
	logic [QLVL_W-1:0] q_level;
	bk_stat_t          bk_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_width    <= DIM_W'(1);
			cfg_q.plane_height   <= DIM_W'(1);
			cfg_q.channel_select <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  cfg_q.plane_width    <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: cfg_q.plane_height   <= cfg_data[DIM_W-1:0];
				CFG_LANE:   cfg_q.channel_select <= cfg_data[LANE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pbd_front u_front (
		.byte_ch   (byte_ch),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	pbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (bk_stat.pop),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_full    (q_full),
		.q_level   (q_level)
	);

	pbd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.run_ch  (run_ch),
		.stat    (bk_stat)
	);

	// checks
	`PBD_ASSERT_NOW(a_status_only_reason, run_ch.valid && run_ch.run_length == '0, run_ch.status != ST_OK || run_ch.plane_done, "status-only item without a reason")
	`PBD_ASSERT_NOW(a_run_bound, run_ch.valid, run_ch.run_length <= RUN_MAX, "run longer than a packet")
	`PBD_ASSERT_NOW(a_pop_nonempty, bk_stat.pop, q_level != '0, "back end took from an empty queue")
	`PBD_ASSERT_NEXT(a_push_lands, byte_ch.valid && byte_ch.ready && !bk_stat.pop, q_level != '0, "accepted item missing from queue")
	`PBD_ASSERT_NOW(a_walk_holds, bk_stat.walking, !bk_stat.pop, "back end took an item during a count walk")

endmodule

`default_nettype wire

### rtl/core/pbd_front.sv
// front end: takes plane bytes and pre-decodes packbits header fields
`default_nettype none

module pbd_front import pbd_pkg::*; (
	pbd_in_if.sink    byte_ch,
	input  logic      q_full,
	output logic      push,
	output item_t     push_item
);

	// accept whenever the queue has room
	assign byte_ch.ready = !q_full;
	assign push          = byte_ch.valid && !q_full;

	// header classification, used by the back end only when the byte is a header
	always_comb begin
		push_item.data_byte = byte_ch.data_byte;
		push_item.last_byte = byte_ch.last_byte;
		push_item.is_lit    = byte_ch.data_byte < PB_NOOP;
		push_item.is_noop   = byte_ch.data_byte == PB_NOOP;
		push_item.lit_len   = byte_ch.data_byte + LEN_W'(1);
		push_item.rep_len   = LEN_W'(PB_REP_BASE - {1'b0, byte_ch.data_byte});
	end

endmodule

`default_nettype wire

### rtl/core/pbd_queue.sv
// small item queue between front and back end
`default_nettype none

module pbd_queue import pbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  item_t             push_item,
	input  logic              pop,
	output logic              q_valid,
	output item_t             q_item,
	output logic              q_full,
	output logic [QLVL_W-1:0] q_level
);

	item_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QLVL_W-1:0] level_q;

	assign q_valid = level_q != '0;
	assign q_full  = level_q == QLVL_W'(QDEPTH);
	assign q_item  = entry_q[rd_q];
	assign q_level = level_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + QLVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - QLVL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/pbd_back.sv
// back end: plane decode sequencer, row count table and result register
`default_nettype none

module pbd_back import pbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  item_t      q_item,
	pbd_out_if.source  run_ch,
	output bk_stat_t   stat
);

	localparam logic [1:0] BK_RUN = 2'd0;
	localparam logic [1:0] BK_RD  = 2'd1;
	localparam logic [1:0] BK_CHK = 2'd2;

	// decode state
	logic [1:0]        bstate_q, n_bstate;
	logic [PH_W-1:0]   phase_q, n_phase;
	logic              mode_q, n_mode;
	logic [BYTE_W-1:0] hdr_q, n_hdr;
	logic [ROW_W-1:0]  row_q, n_row;
	logic [DIM_W-1:0]  col_q, n_col;
	logic [CNT_W-1:0]  left_q, n_left;
	logic [LEN_W-1:0]  lit_q, n_lit;
	logic [LEN_W-1:0]  rep_q, n_rep;
	logic [BASE_W-1:0] base_q, n_base;

	// result held across a row count walk
	result_t pend_q, n_pend;
	logic    pend_last_q, n_pend_last;
	logic    pend_active_q, n_pend_active;

	// output register
	result_t out_q;
	logic    out_valid_q;
	result_t fin_res;
	logic    fin_go;
	logic    slot_free;
	logic    pop;

	// row count table
	logic [CNT_W-1:0] count_mem_q [MAX_ROWS];
	logic [CNT_W-1:0] cnt_rd_q;
	logic             cnt_we;
	logic             cnt_re;

	// effective plane size and next row start
	logic [DIM_W-1:0]         eff_w;
	logic [DIM_W-1:0]         eff_h;
	logic [ROW_W:0]           row_nx;
	logic [ROW_W+DIM_W:0]     row_prod;
	logic [BASE_W-1:0]        next_base;
	logic                     last_row;

	assign eff_w = (cfg.plane_width == '0) ? DIM_W'(1) :
		(cfg.plane_width > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg.plane_width;
	assign eff_h = (cfg.plane_height == '0) ? DIM_W'(1) :
		(cfg.plane_height > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg.plane_height;
	assign row_nx    = {1'b0, row_q} + (ROW_W+1)'(1);
	assign row_prod  = row_nx * eff_w;
	assign next_base = row_prod[BASE_W-1:0];
	assign last_row  = DIM_W'(row_nx) >= eff_h;

	assign slot_free    = !out_valid_q || run_ch.ready;
	assign stat.pop     = pop;
	assign stat.walking = bstate_q != BK_RUN;

	// one decode step per cycle while an item waits and the output slot is free, or one step of the row count walk
	always_comb begin
		result_t           res;
		logic [DIM_W-1:0]  room;
		logic              emit_en;
		logic [LEN_W-1:0]  emit_len;
		logic              walk;
		logic              fin_last;
		logic              fin_active;
		logic [BYTE_W-1:0] b;

		res           = '0;
		room          = '0;
		emit_en       = 1'b0;
		emit_len      = '0;
		walk          = 1'b0;
		fin_last      = 1'b0;
		fin_active    = 1'b0;
		fin_go        = 1'b0;
		b             = q_item.data_byte;
		pop           = 1'b0;
		cnt_we        = 1'b0;
		cnt_re        = 1'b0;
		n_bstate      = bstate_q;
		n_phase       = phase_q;
		n_mode        = mode_q;
		n_hdr         = hdr_q;
		n_row         = row_q;
		n_col         = col_q;
		n_left        = left_q;
		n_lit         = lit_q;
		n_rep         = rep_q;
		n_base        = base_q;
		n_pend        = pend_q;
		n_pend_last   = pend_last_q;
		n_pend_active = pend_active_q;

		unique case (bstate_q)
			BK_RUN: begin
				if (q_valid && slot_free) begin
					pop        = 1'b1;
					fin_last   = q_item.last_byte;
					fin_active = phase_q != PH_SINK;
					unique case (phase_q)
						PH_HDR_HI: begin
							n_hdr   = b;
							n_phase = PH_HDR_LO;
						end
						PH_HDR_LO: begin
							n_row  = '0;
							n_col  = '0;
							n_base = '0;
							n_lit  = '0;
							n_rep  = '0;
							n_left = '0;
							if (hdr_q == '0 && b == 8'd0) begin
								n_mode  = 1'b0;
								n_phase = PH_DATA;
							end else if (hdr_q == '0 && b == 8'd1) begin
								n_mode  = 1'b1;
								n_phase = PH_CNT_HI;
							end else begin
								res.status = ST_BAD_COMP;
								res.done   = 1'b1;
								n_phase    = PH_SINK;
							end
						end
						PH_CNT_HI: begin
							n_hdr   = b;
							n_phase = PH_CNT_LO;
						end
						PH_CNT_LO: begin
							cnt_we = 1'b1;
							if (last_row) begin
								n_phase = PH_DATA;
								n_row   = '0;
								n_col   = '0;
								n_base  = '0;
								n_lit   = '0;
								n_rep   = '0;
								walk    = 1'b1;
							end else begin
								n_row   = row_nx[ROW_W-1:0];
								n_phase = PH_CNT_HI;
							end
						end
						PH_DATA: begin
							if (DIM_W'(row_q) >= eff_h) begin
								res.done = 1'b1;
								n_phase  = PH_SINK;
							end else begin
								room = (col_q < eff_w) ? (eff_w - col_q) : '0;
								// pick what this byte contributes
								if (mode_q) begin
									if (rep_q != '0) begin
										if (room != '0) begin
											emit_en = 1'b1;
											if ({{(DIM_W-LEN_W){1'b0}}, rep_q} > room) begin
												emit_len   = room[LEN_W-1:0];
												res.status = ST_OVERFLOW;
											end else begin
												emit_len = rep_q;
											end
										end
										n_rep = '0;
									end else if (lit_q != '0) begin
										n_lit    = lit_q - LEN_W'(1);
										emit_en  = room != '0;
										emit_len = LEN_W'(1);
									end else if (room != '0) begin
										if (q_item.is_lit) begin
											n_lit = q_item.lit_len;
											if ({{(DIM_W-LEN_W){1'b0}}, q_item.lit_len} > room) begin
												res.status = ST_OVERFLOW;
											end
										end else if (!q_item.is_noop) begin
											n_rep = q_item.rep_len;
										end
									end
								end else begin
									emit_en  = room != '0;
									emit_len = LEN_W'(1);
								end
								// run descriptor
								if (emit_en) begin
									res.run  = 1'b1;
									res.addr = {base_q, cfg.channel_select};
									res.val  = b;
									res.len  = emit_len;
									n_col    = col_q + {{(DIM_W-LEN_W){1'b0}}, emit_len};
									n_base   = base_q + {{(BASE_W-LEN_W){1'b0}}, emit_len};
								end
								// row bookkeeping
								if (mode_q) begin
									n_left = (left_q != '0) ? left_q - CNT_W'(1) : left_q;
									if (n_left == '0) begin
										if (n_col < eff_w && res.status == ST_OK) begin
											res.status = ST_SHORT;
										end
										n_lit = '0;
										n_rep = '0;
										if (last_row) begin
											res.done = 1'b1;
											n_phase  = PH_SINK;
										end else begin
											n_row  = row_nx[ROW_W-1:0];
											n_col  = '0;
											n_base = next_base;
											walk   = 1'b1;
										end
									end
								end else if (n_col >= eff_w) begin
									if (last_row) begin
										res.done = 1'b1;
										n_phase  = PH_SINK;
									end else begin
										n_row  = row_nx[ROW_W-1:0];
										n_col  = '0;
										n_base = next_base;
										n_lit  = '0;
										n_rep  = '0;
									end
								end
							end
						end
						default: begin
						end
					endcase
					if (walk) begin
						n_pend        = res;
						n_pend_last   = q_item.last_byte;
						n_pend_active = fin_active;
						n_bstate      = BK_RD;
					end else begin
						fin_go = 1'b1;
					end
				end
			end
			BK_RD: begin
				// fetch the count of the row just opened
				cnt_re   = 1'b1;
				n_bstate = BK_CHK;
			end
			BK_CHK: begin
				if (slot_free) begin
					res        = pend_q;
					fin_last   = pend_last_q;
					fin_active = pend_active_q;
					n_left     = cnt_rd_q;
					if (cnt_rd_q != '0) begin
						fin_go   = 1'b1;
						n_bstate = BK_RUN;
					end else begin
						// empty row: short at once, move on
						if (col_q < eff_w && res.status == ST_OK) begin
							res.status = ST_SHORT;
						end
						n_lit = '0;
						n_rep = '0;
						if (last_row) begin
							res.done = 1'b1;
							n_phase  = PH_SINK;
							fin_go   = 1'b1;
							n_bstate = BK_RUN;
						end else begin
							n_row    = row_nx[ROW_W-1:0];
							n_col    = '0;
							n_base   = next_base;
							n_pend   = res;
							n_bstate = BK_RD;
						end
					end
				end
			end
			default: begin
				n_bstate = BK_RUN;
			end
		endcase

		// end of buffer closes the plane and rearms for the next header
		if (fin_go && fin_last) begin
			if (fin_active && n_phase != PH_SINK) begin
				res.done = 1'b1;
				if (res.status == ST_OK) begin
					res.status = ST_SHORT;
				end
			end
			n_phase = PH_HDR_HI;
			n_mode  = 1'b0;
			n_hdr   = '0;
			n_row   = '0;
			n_col   = '0;
			n_left  = '0;
			n_lit   = '0;
			n_rep   = '0;
			n_base  = '0;
		end
		fin_res = res;
	end

	// row count table, one write or one read a cycle
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem_q[row_q] <= {hdr_q, q_item.data_byte};
		end
		if (cnt_re) begin
			cnt_rd_q <= count_mem_q[row_q];
		end
	end

	// pending result of a walk
	always_ff @(posedge clk) begin
		pend_q        <= n_pend;
		pend_last_q   <= n_pend_last;
		pend_active_q <= n_pend_active;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q <= fin_res;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q    <= BK_RUN;
			phase_q     <= PH_HDR_HI;
			mode_q      <= 1'b0;
			hdr_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			left_q      <= '0;
			lit_q       <= '0;
			rep_q       <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			bstate_q <= n_bstate;
			phase_q  <= n_phase;
			mode_q   <= n_mode;
			hdr_q    <= n_hdr;
			row_q    <= n_row;
			col_q    <= n_col;
			left_q   <= n_left;
			lit_q    <= n_lit;
			rep_q    <= n_rep;
			base_q   <= n_base;
			if (slot_free) begin
				out_valid_q <= fin_go && (fin_res.run || fin_res.done ||
					fin_res.status != ST_OK);
			end
		end
	end

	assign run_ch.valid        = out_valid_q;
	assign run_ch.dest_address = out_q.addr;
	assign run_ch.pixel_value  = out_q.val;
	assign run_ch.run_length   = out_q.len;
	assign run_ch.status       = out_q.status;
	assign run_ch.plane_done   = out_q.done;

endmodule

`default_nettype wire

### tb/tb.sv
// testbench for the packbits plane decoder: byte streams in, predicted runs checked out
`timescale 1ns / 100ps

module tb import pbd_pkg::*; ();

	localparam int WATCHDOG = 40000;
	localparam int RAND_ITEMS = 700;
	localparam int CALM_ITEMS = 600;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] val;
		logic [LEN_W-1:0]  len;
		logic [STAT_W-1:0] status;
		logic              done;
	} run_t;

	typedef enum int {
		ROW_EXACT, ROW_PADDED, ROW_LIT_OVER, ROW_REP_OVER, ROW_SHORT, ROW_EMPTY, ROW_NOISE
	} row_kind_t;

	// plane decode prediction and run checking
	class plane_run_board;
		logic [DIM_W-1:0]  width_cfg;
		logic [DIM_W-1:0]  height_cfg;
		logic [LANE_W-1:0] lane_cfg;

		logic [PH_W-1:0]   phase;
		bit                rle_mode;
		logic [BYTE_W-1:0] hi_byte;
		logic [CNT_W-1:0]  row_counts [MAX_ROWS];
		int unsigned       row, col, row_left, lit_left, rep_left;
		logic [BASE_W-1:0] pbase;

		// run being built for the current byte
		bit                got_run, got_done;
		run_t              step_run;

		run_t              pending_runs[$];
		int                errors;

		function new();
			width_cfg = 1;
			height_cfg = 1;
			lane_cfg = 0;
			errors = 0;
			rearm();
		endfunction

		function int unsigned eff_w();
			int unsigned v;
			v = width_cfg;
			if (v == 0) v = 1;
			if (v > MAX_COLS) v = MAX_COLS;
			return v;
		endfunction

		function int unsigned eff_h();
			int unsigned v;
			v = height_cfg;
			if (v == 0) v = 1;
			if (v > MAX_ROWS) v = MAX_ROWS;
			return v;
		endfunction

		// first status seen in a step wins
		function void flag(logic [STAT_W-1:0] s);
			if (step_run.status == ST_OK) step_run.status = s;
		endfunction

		function void end_plane();
			got_done = 1;
			phase = PH_SINK;
		endfunction

		function void emit(logic [BYTE_W-1:0] v, int unsigned n);
			got_run = 1;
			step_run.addr = {pbase, 2'b00} + ADDR_W'(lane_cfg);
			step_run.val = v;
			step_run.len = LEN_W'(n);
			col += n;
			pbase = pbase + BASE_W'(n);
		endfunction

		function int unsigned count_of(int unsigned r);
			return (r < MAX_ROWS) ? int'(row_counts[r]) : 0;
		endfunction

		function void open_row(int unsigned r);
			row = r;
			col = 0;
			pbase = BASE_W'(r * eff_w());
			lit_left = 0;
			rep_left = 0;
		endfunction

		function void rearm();
			phase = PH_HDR_HI;
			rle_mode = 0;
			hi_byte = 0;
			row = 0;
			col = 0;
			row_left = 0;
			lit_left = 0;
			rep_left = 0;
			pbase = 0;
		endfunction

		// row count used up: close it and move to the next row with bytes
		function void close_row();
			while (1'b1) begin
				if (col < eff_w()) flag(ST_SHORT);
				lit_left = 0;
				rep_left = 0;
				if (row + 1 >= eff_h()) begin
					end_plane();
					return;
				end
				open_row(row + 1);
				row_left = count_of(row);
				if (row_left != 0) return;
			end
		endfunction

		function void rle_step(logic [BYTE_W-1:0] b, int unsigned w);
			int unsigned room, n;
			room = (col < w) ? w - col : 0;
			if (rep_left != 0) begin
				if (room != 0) begin
					n = rep_left;
					if (n > room) begin
						n = room;
						flag(ST_OVERFLOW);
					end
					emit(b, n);
				end
				rep_left = 0;
			end else if (lit_left != 0) begin
				lit_left = lit_left - 1;
				if (room != 0) emit(b, 1);
			end else if (room != 0) begin
				// packet header
				if (b < PB_NOOP) begin
					lit_left = b + 1;
					if (lit_left > room) flag(ST_OVERFLOW);
				end else if (b != PB_NOOP) begin
					rep_left = PB_REP_BASE - b;
				end
			end
			if (row_left != 0) row_left = row_left - 1;
			if (row_left == 0) close_row();
		endfunction

		function void raw_step(logic [BYTE_W-1:0] b, int unsigned w, int unsigned h);
			if (col < w) emit(b, 1);
			if (col >= w) begin
				if (row + 1 >= h) begin
					end_plane();
					return;
				end
				open_row(row + 1);
			end
		endfunction

		// one accepted byte: advance the decoder and queue its run, if any
		function void decode_byte(logic [BYTE_W-1:0] b, logic last);
			int unsigned w, h;
			bit live;
			logic [15:0] code;
			w = eff_w();
			h = eff_h();
			live = (phase != PH_SINK);
			got_run = 0;
			got_done = 0;
			step_run = '0;
			case (phase)
				PH_HDR_HI: begin
					hi_byte = b;
					phase = PH_HDR_LO;
				end
				PH_HDR_LO: begin
					code = {hi_byte, b};
					open_row(0);
					row_left = 0;
					if (code == 16'd0) begin
						rle_mode = 0;
						phase = PH_DATA;
					end else if (code == 16'd1) begin
						rle_mode = 1;
						phase = PH_CNT_HI;
					end else begin
						flag(ST_BAD_COMP);
						end_plane();
					end
				end
				PH_CNT_HI: begin
					hi_byte = b;
					phase = PH_CNT_LO;
				end
				PH_CNT_LO: begin
					if (row < MAX_ROWS) row_counts[row] = {hi_byte, b};
					if (row + 1 >= h) begin
						phase = PH_DATA;
						open_row(0);
						row_left = count_of(0);
						if (row_left == 0) close_row();
					end else begin
						row = row + 1;
						phase = PH_CNT_HI;
					end
				end
				PH_DATA: begin
					if (row >= h) end_plane();
					else if (rle_mode) rle_step(b, w);
					else raw_step(b, w, h);
				end
				default: ;
			endcase
			// end of buffer
			if (last) begin
				if (live && phase != PH_SINK) begin
					got_done = 1;
					flag(ST_SHORT);
				end
				rearm();
			end
			if (got_run || got_done || step_run.status != ST_OK) begin
				step_run.done = got_done;
				pending_runs = {pending_runs, step_run};
			end
		endfunction

		function void check_run(run_t got);
			run_t want;
			if (pending_runs.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected run: addr %0h val %0h len %0d status %0d done %0b",
						got.addr, got.val, got.len, got.status, got.done);
				return;
			end
			want = pending_runs.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"run differs: expected addr %0h val %0h len %0d status %0d done %0b,",
						" got addr %0h val %0h len %0d status %0d done %0b"},
						want.addr, want.val, want.len, want.status, want.done,
						got.addr, got.val, got.len, got.status, got.done);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pbd_in_if byte_ch();
	pbd_out_if run_ch();

	packbits_plane_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.run_ch    (run_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	plane_run_board sb;
	logic [BYTE_W-1:0] stream[$];
	logic [BYTE_W-1:0] body[$];
	bit calm = 1'b0;
	bit tx_idle = 1'b1;
	bit stall_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	run_t seen_run;

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run channel stalls in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			run_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			run_ch.ready <= 1'b0;
		end else if (stall_on && !calm && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 17);
			run_ch.ready <= 1'b0;
		end else begin
			run_ch.ready <= 1'b1;
		end
	end

	// predict on accepted bytes, check accepted runs, watchdog
	always @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready)
			sb.decode_byte(byte_ch.data_byte, byte_ch.last_byte);
		if (run_ch.valid && run_ch.ready) begin
			seen_run = {run_ch.dest_address, run_ch.pixel_value, run_ch.run_length,
				run_ch.status, run_ch.plane_done};
			sb.check_run(seen_run);
		end
		if ((byte_ch.valid && byte_ch.ready) || (run_ch.valid && run_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG) begin
			$display("packbits_plane_decoder: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one byte item, with an optional gap before it
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		if (tx_idle && !calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 18);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= last;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	// send the built stream, last_byte on its final byte when closing
	task automatic send_stream(input bit close);
		int unsigned i;
		for (i = 0; i < stream.size(); i++) begin
			if (!calm && $urandom_range(0, 79) == 0) drain();
			push_byte(stream[i], close && (i == stream.size() - 1));
		end
	endtask

	// hold off until every predicted run is out
	task automatic drain();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_runs.size() != 0) @(posedge clk);
	endtask

	// idle long enough for zero-count row reads to finish
	task automatic settle();
		drain();
		repeat (16 + 3 * sb.eff_h()) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned wv, input int unsigned hv,
		input int unsigned lane);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= CFG_DATA_W'(wv);
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= CFG_DATA_W'(hv);
		@(posedge clk);
		cfg_index <= CFG_LANE;
		cfg_data <= CFG_DATA_W'(lane);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.width_cfg = DIM_W'(wv);
		sb.height_cfg = DIM_W'(hv);
		sb.lane_cfg = LANE_W'(lane);
	endtask

	// append one byte to the row bodies
	function automatic void put_body(input logic [BYTE_W-1:0] v);
		body = {body, v};
	endfunction

	// append one byte to the stream
	function automatic void put_stream(input logic [BYTE_W-1:0] v);
		stream = {stream, v};
	endfunction

	// packbits packets covering exactly the given pixels
	function automatic void fill_pixels(input int unsigned room);
		int unsigned n;
		while (room > 0) begin
			if ($urandom_range(0, 9) == 0) put_body(PB_NOOP);
			if (room >= 2 && $urandom_range(0, 3) < ((room > 16) ? 3 : 2)) begin
				n = $urandom_range(2, (room < 128) ? room : 128);
				put_body(8'(PB_REP_BASE - n));
				put_body(8'($urandom));
			end else begin
				n = $urandom_range(1, (room < 128) ? room : 128);
				put_body(8'(n - 1));
				repeat (n) put_body(8'($urandom));
			end
			room -= n;
		end
	endfunction

	function automatic void add_row(input int unsigned w, input row_kind_t k);
		int unsigned room, n;
		room = $urandom_range(1, (w < 127) ? w : 127);
		case (k)
			ROW_EXACT: fill_pixels(w);
			ROW_PADDED: begin
				fill_pixels(w);
				repeat ($urandom_range(1, 4)) put_body(8'($urandom));
			end
			ROW_LIT_OVER: begin
				fill_pixels(w - room);
				if ($urandom_range(0, 3) == 0) n = $urandom_range(room + 1, 128);
				else n = $urandom_range(room + 1, (room + 3 < 128) ? room + 3 : 128);
				put_body(8'(n - 1));
				repeat (n) put_body(8'($urandom));
			end
			ROW_REP_OVER: begin
				fill_pixels(w - room);
				n = $urandom_range(room + 1, 128);
				put_body(8'(PB_REP_BASE - n));
				put_body(8'($urandom));
			end
			ROW_SHORT: fill_pixels($urandom_range(0, w - 1));
			ROW_NOISE: repeat ($urandom_range(1, 6)) put_body(8'($urandom));
			default: ;
		endcase
	endfunction

	// packbits plane: code, row counts, row bodies
	function automatic void build_rle(input int unsigned w, input int unsigned h,
		input bit sparse);
		int unsigned cnt[];
		int unsigned r, start;
		row_kind_t k;
		cnt = new[h];
		body.delete();
		for (r = 0; r < h; r++) begin
			start = body.size();
			if (sparse) begin
				k = (r == h - 1 || $urandom_range(0, 19) == 0) ? ROW_EXACT : ROW_EMPTY;
			end else begin
				case ($urandom_range(0, 9))
					4: k = ROW_PADDED;
					5: k = ROW_LIT_OVER;
					6: k = ROW_REP_OVER;
					7: k = ROW_SHORT;
					8: k = ROW_EMPTY;
					9: k = ROW_NOISE;
					default: k = ROW_EXACT;
				endcase
			end
			add_row(w, k);
			cnt[r] = body.size() - start;
		end
		stream = {8'h00, 8'h01};
		for (r = 0; r < h; r++) begin
			put_stream(8'(cnt[r] >> 8));
			put_stream(8'(cnt[r]));
		end
		foreach (body[i]) put_stream(body[i]);
	endfunction

	function automatic void build_raw(input int unsigned w, input int unsigned h);
		stream = {8'h00, 8'h00};
		repeat (w * h) put_stream(8'($urandom));
	endfunction

	initial begin
		int rand_items;
		int unsigned wv, hv, cut;
		int unsigned code;
		int plane_kind;

		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// raw plane, two pixels on the alpha lane
		set_config(2, 1, 3);
		stream = {8'h00, 8'h00, 8'hFF, 8'h00};
		send_stream(1);
		settle();

		// no-op header, repeat of two, then a row with a zero count
		set_config(2, 2, 1);
		stream = {8'h00, 8'h01, 8'h00, 8'h03, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hAA};
		send_stream(1);
		settle();

		// unknown compression code, trailing byte ignored
		stream = {8'h12, 8'h34, 8'h56};
		send_stream(1);
		settle();

		// literal longer than the row
		set_config(2, 1, 0);
		stream = {8'h00, 8'h01, 8'h00, 8'h03, 8'h02, 8'h00, 8'hFF};
		send_stream(1);
		settle();

		// buffer ends inside the header
		stream = {8'h00};
		send_stream(1);
		settle();

		// height lowered mid-plane ends it at once
		set_config(2, 4, 2);
		stream = {8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44};
		send_stream(0);
		settle();
		set_config(2, 1, 2);
		stream = {8'h55};
		send_stream(1);
		settle();

		// widest rows: sparse packbits plane with the width above the limit
		set_config(2047, 6, $urandom_range(0, 3));
		build_rle(sb.eff_w(), sb.eff_h(), 1);
		send_stream(1);
		settle();

		// random planes, mostly small
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			calm = (rand_items >= CALM_ITEMS);
			tx_idle = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			plane_kind = $urandom_range(0, 9);
			case ($urandom_range(0, 19))
				0: wv = 0;
				1: wv = (plane_kind < 6) ? $urandom_range(100, 160) : 16;
				2: wv = 1;
				default: wv = $urandom_range(2, 12);
			endcase
			case ($urandom_range(0, 9))
				0: hv = 0;
				1: hv = 1;
				default: hv = $urandom_range(2, 5);
			endcase
			set_config(wv, hv, $urandom_range(0, 3));
			if (plane_kind < 6) begin
				build_rle(sb.eff_w(), sb.eff_h(), 0);
			end else if (plane_kind < 9) begin
				build_raw(sb.eff_w(), sb.eff_h());
			end else begin
				code = $urandom_range(2, 65535);
				stream = {8'(code >> 8), 8'(code)};
				repeat ($urandom_range(0, 4)) put_stream(8'($urandom));
			end
			// cut the buffer short or add junk after the plane
			case ($urandom_range(0, 5))
				0: if (stream.size() > 1) begin
					cut = $urandom_range(1, stream.size() - 1);
					while (stream.size() > cut) void'(stream.pop_back());
				end
				1: repeat ($urandom_range(1, 4)) put_stream(8'($urandom));
				default: ;
			endcase
			rand_items += stream.size();
			send_stream(1);
			settle();
		end

		if (sb.errors == 0 && sb.pending_runs.size() == 0)
			$display("packbits_plane_decoder: match");
		else
			$display("packbits_plane_decoder: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pbd_pkg.sv
rtl/core/pbd_stream_if.sv
rtl/core/pbd_front.sv
rtl/core/pbd_queue.sv
rtl/core/pbd_back.sv
rtl/core/packbits_plane_decoder.sv
tb/tb.sv
